### design/hvn_pkg.sv
// shared types and constants for the hashed value noise block
`default_nettype none
package hvn_pkg;
    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 10;
    localparam int QUO_W   = DATA_W + FRAC_W;
    localparam int NCELLS  = QUO_W;
    localparam int OUT_W   = 11;
    localparam int SMOOTH_W = 10;

    localparam logic [31:0] HASH_MUL_A = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL_B = 32'h846ca68b;
    localparam logic [31:0] INDEX_MUL  = 32'h9e3779b9;
    localparam logic [31:0] INDEX_ADD  = 32'h85ebca6b;
    localparam logic [31:0] PERIOD_RST = 32'd1024;
    localparam logic [31:0] SEED_RST   = 32'd0;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_SEED   = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] num;
        logic [QUO_W-1:0]  quo;
    } t_div;
endpackage
`default_nettype wire

### design/hvn_if.sv
// stream interfaces for time input and noise output
`default_nettype none
interface hvn_time_if;
    logic        valid;
    logic        ready;
    logic [31:0] time_value;
    modport source (output valid, output time_value, input ready);
    modport sink (input valid, input time_value, output ready);
endinterface

interface hvn_noise_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] noise_value;
    modport source (output valid, output noise_value, input ready);
    modport sink (input valid, input noise_value, output ready);
endinterface
`default_nettype wire

### design/hvn_div_cell.sv
// one restoring division cell, one quotient bit per cell
`default_nettype none
module hvn_div_cell import hvn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_div              i_d,
    input  wire logic [DATA_W-1:0] i_period,
    output logic                   o_valid,
    output t_div                   o_d
);
    logic        r_valid;
    t_div        r_d;
    t_div        n_d;
    logic [DATA_W:0] w_sh;
    logic [DATA_W:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_sh   = {i_d.rem, i_d.num[DATA_W-1]};
        w_diff = w_sh - {1'b0, i_period};
        w_ge   = w_sh >= {1'b0, i_period};
        n_d.rem = w_ge ? w_diff[DATA_W-1:0] : w_sh[DATA_W-1:0];
        n_d.num = {i_d.num[DATA_W-2:0], 1'b0};
        n_d.quo = {i_d.quo[QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
endmodule
`default_nettype wire

### design/hvn_hash_lane.sv
// pipelined lattice hash, index to signed q10 value in four stages
`default_nettype none
module hvn_hash_lane import hvn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [DATA_W-1:0] i_index,
    input  wire logic [DATA_W-1:0] i_seed,
    output logic signed [OUT_W-1:0] o_value
);
    logic [DATA_W-1:0] r_m;
    logic [DATA_W-1:0] r_y;
    logic [DATA_W-1:0] r_w;
    logic signed [OUT_W-1:0] r_v;
    logic [DATA_W-1:0] w_x;
    logic [DATA_W-1:0] w_z;
    logic [DATA_W-1:0] w_h;

    always_comb begin
        w_x = i_seed ^ (r_m + INDEX_ADD);
        w_z = r_y ^ (r_y >> 15);
        w_h = r_w ^ (r_w >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= i_index * INDEX_MUL;
            r_y <= (w_x ^ (w_x >> 16)) * HASH_MUL_A;
            r_w <= w_z * HASH_MUL_B;
            r_v <= {~w_h[OUT_W-1], w_h[OUT_W-2:0]};
        end
    end

    assign o_value = r_v;
endmodule
`default_nettype wire

### design/hashed_value_noise_1d.sv
// top level of the hashed value noise block
// One noise sample per transaction; a new time value is taken every cycle while the
// output is free, and each time value passes in turn through 42 division
// cells (32 index bits, 10 fraction bits), four hash and smoothstep stages and the
// output register. The whole pipeline stalls when a result waits to be taken.
// Configuration writes must happen while the pipeline is empty.
`default_nettype none
module hashed_value_noise_1d import hvn_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    hvn_time_if.sink               i_time,
    hvn_noise_if.source            o_noise,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [DATA_W-1:0] i_cfg_data
);
    logic [DATA_W-1:0] r_period;
    logic [DATA_W-1:0] r_seed;
    logic              w_en;
    logic [NCELLS:0]   w_cv;
    t_div              w_cd [NCELLS+1];
    logic [DATA_W-1:0] w_k;
    logic [FRAC_W-1:0] w_f;
    logic [DATA_W-1:0] w_k1;
    logic signed [OUT_W-1:0] w_a;
    logic signed [OUT_W-1:0] w_b;
    logic [3:0]        r_sv;
    logic [FRAC_W-1:0] r_f1;
    logic [FRAC_W-1:0] r_f2;
    logic [2*FRAC_W-1:0] r_sq;
    logic [SMOOTH_W-1:0] r_s3;
    logic [SMOOTH_W-1:0] r_s4;
    logic [31:0]       w_poly;
    logic signed [OUT_W:0] w_d;
    logic signed [2*OUT_W:0] w_prod;
    logic signed [OUT_W:0] w_step;
    logic signed [OUT_W:0] w_sum;
    logic              r_out_valid;
    logic signed [OUT_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_seed   <= SEED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PERIOD: r_period <= i_cfg_data;
                REG_SEED:   r_seed   <= i_cfg_data;
                default:    r_seed   <= r_seed;
            endcase
        end
    end

    assign w_en         = !r_out_valid || o_noise.ready;
    assign i_time.ready = w_en;

    assign w_cv[0]     = i_time.valid;
    assign w_cd[0].rem = '0;
    assign w_cd[0].num = i_time.time_value;
    assign w_cd[0].quo = '0;

    for (genvar g = 0; g < NCELLS; g++) begin : g_cell
        hvn_div_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (w_cv[g]),
            .i_d      (w_cd[g]),
            .i_period (r_period),
            .o_valid  (w_cv[g+1]),
            .o_d      (w_cd[g+1])
        );
    end

    assign w_k  = w_cd[NCELLS].quo[QUO_W-1:FRAC_W];
    assign w_f  = w_cd[NCELLS].quo[FRAC_W-1:0];
    assign w_k1 = w_k + 32'd1;

    hvn_hash_lane u_lane_a (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_index (w_k),
        .i_seed  (r_seed),
        .o_value (w_a)
    );

    hvn_hash_lane u_lane_b (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_index (w_k1),
        .i_seed  (r_seed),
        .o_value (w_b)
    );

    // smoothstep: (3*f^2*1024 - 2*f^3) >> 20
    assign w_poly = 32'(3 * {2'b0, r_sq, 10'b0}) - 32'(2 * 32'(r_sq) * 32'(r_f2));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1 <= w_f;
            r_f2 <= r_f1;
            r_sq <= r_f1 * r_f1;
            r_s3 <= w_poly[29:20];
            r_s4 <= r_s3;
        end
    end

    always_comb begin
        w_d    = {w_b[OUT_W-1], w_b} - {w_a[OUT_W-1], w_a};
        w_prod = w_d * $signed({2'b0, r_s4});
        w_step = w_prod[2*OUT_W-1:FRAC_W];
        w_sum  = {w_a[OUT_W-1], w_a} + w_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv        <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_sv        <= {r_sv[2:0], w_cv[NCELLS]};
            r_out_valid <= r_sv[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= (r_period == '0) ? '0 : w_sum[OUT_W-1:0];
        end
    end

    assign o_noise.valid       = r_out_valid;
    assign o_noise.noise_value = r_out;

    a_zero_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_period == '0) |-> (r_out == '0))
        else $error("nonzero noise with zero period");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_noise.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_noise.ready) |-> !i_time.ready)
        else $error("input taken while pipeline stalled");
endmodule
`default_nettype wire

### tb/sv/hashed_value_noise_1d_checker.sv
// checker that predicts noise samples and compares them with the block output
`timescale 1ns / 100ps
module hashed_value_noise_1d_checker import hvn_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hvn_time_if              time_ch,
    hvn_noise_if             noise_ch,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    logic [31:0] period_ticks;
    logic [31:0] noise_seed;
    logic signed [10:0] noise_queue[$];

    function automatic logic signed [31:0] lattice_point(input logic [31:0] k,
                                                          input logic [31:0] seed);
        logic [31:0] h;
        h = seed ^ (k * INDEX_MUL + INDEX_ADD);
        h = h ^ (h >> 16);
        h = h * HASH_MUL_A;
        h = h ^ (h >> 15);
        h = h * HASH_MUL_B;
        h = h ^ (h >> 16);
        return $signed({21'd0, h[10:0]}) - 32'sd1024;
    endfunction

    function automatic logic signed [10:0] noise_sample(input logic [31:0] t,
                                                        input logic [31:0] per,
                                                        input logic [31:0] seed);
        logic [31:0] k;
        logic [31:0] rem;
        logic [63:0] f;
        logic [63:0] s;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] prod;
        if (per == 0) begin
            return 11'sd0;
        end
        k = t / per;
        rem = t % per;
        f = ({32'd0, rem} << 10) / {32'd0, per};
        s = (3 * ((f * f) << 10) - 2 * f * f * f) >> 20;
        a = lattice_point(k, seed);
        b = lattice_point(k + 32'd1, seed);
        prod = (b - a) * $signed(s[31:0]);
        return 11'(a + (prod >>> 10));
    endfunction

    assign o_pending = noise_queue.size();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period_ticks <= PERIOD_RST;
            noise_seed <= SEED_RST;
            noise_queue.delete();
            o_fail_count <= 0;
            o_checked <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PERIOD) begin
                    period_ticks <= i_cfg_data;
                end else begin
                    noise_seed <= i_cfg_data;
                end
            end
            if (time_ch.valid && time_ch.ready) begin
                noise_queue.push_back(noise_sample(time_ch.time_value, period_ticks,
                                                   noise_seed));
            end
            if (noise_ch.valid && noise_ch.ready) begin
                o_checked <= o_checked + 1;
                if (noise_queue.size() == 0) begin
                    $error("unexpected transaction noise_value %0d", noise_ch.noise_value);
                    o_fail_count <= o_fail_count + 1;
                end else if (noise_queue[0] !== noise_ch.noise_value) begin
                    $error("noise_value expected %0d actual %0d", noise_queue[0],
                           noise_ch.noise_value);
                    o_fail_count <= o_fail_count + 1;
                    void'(noise_queue.pop_front());
                end else begin
                    void'(noise_queue.pop_front());
                end
            end
        end
    end
endmodule

### tb/sv/hashed_value_noise_1d_test.sv
// testbench top: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module hashed_value_noise_1d_test import hvn_pkg::*;;
    localparam int LATENCY = 47;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_PERIOD;
    logic [31:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          checked;
    int          cycles = 0;
    int          sent = 0;
    bit          long_stall = 1'b0;
    logic [31:0] period_now = PERIOD_RST;

    hvn_time_if  time_ch();
    hvn_noise_if noise_ch();

    hashed_value_noise_1d dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_time(time_ch), .o_noise(noise_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    hashed_value_noise_1d_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .time_ch(time_ch), .noise_ch(noise_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_checked(checked)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        time_ch.valid = 1'b0;
        time_ch.time_value = '0;
        noise_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int mode;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_stall) begin
                noise_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                long_stall = 1'b0;
            end
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(1, 20)) begin
                noise_ch.ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 5))
            0: return 32'hffffffff - $urandom_range(0, 3000);
            1: return $urandom_range(0, 3000);
            2: return period_now * $urandom_range(0, 8) + $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_time(input logic [31:0] t);
        time_ch.valid <= 1'b1;
        time_ch.time_value <= t;
        @(posedge i_clk);
        while (!time_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_burst(input int count);
        int left;
        left = count;
        while (left > 0) begin
            repeat ($urandom_range(1, 12)) begin
                if (left > 0) begin
                    send_time(pick_time());
                    left--;
                end
            end
            if ($urandom_range(0, 2) == 0) begin
                time_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
        time_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_PERIOD) period_now = value;
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] periods[7];
        logic [31:0] seeds[7];
        periods = '{32'd1024, 32'd0, 32'd1, 32'hffffffff, 32'd3, 32'd1000, 32'h80000000};
        seeds = '{32'd0, 32'hffffffff, 32'h12345678, 32'd0, 32'hdeadbeef, 32'h0, 32'hffffffff};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: field extremes, wrap at the last lattice point, zero period, all-ones period and seed
        send_time(32'd0);
        send_time(32'hffffffff);
        send_time(32'hfffffc00);
        send_time(32'd1023);
        send_time(32'd1024);
        send_time(32'd512);
        send_time(32'haaaaaaaa);
        send_time(32'h55555555);
        time_ch.valid <= 1'b0;
        drain();
        write_reg(REG_PERIOD, 32'd1);
        send_time(32'hffffffff);
        send_time(32'd0);
        time_ch.valid <= 1'b0;
        drain();
        write_reg(REG_PERIOD, 32'd0);
        send_time(32'hffffffff);
        send_time(32'd12345);
        time_ch.valid <= 1'b0;
        drain();
        write_reg(REG_PERIOD, 32'hffffffff);
        write_reg(REG_SEED, 32'hffffffff);
        send_time(32'hfffffffe);
        send_time(32'hffffffff);
        send_time(32'h7fffffff);
        time_ch.valid <= 1'b0;
        drain();
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_PERIOD, (p == 5) ? $urandom_range(1, 100000) : periods[p]);
            write_reg(REG_SEED, (p == 5) ? $urandom : seeds[p]);
            if (p == 2) long_stall = 1'b1;
            send_burst(140);
            drain();
        end
        $display("sent %0d time values over seven period and seed settings", sent);
        $display("checked %0d noise samples including a long output hold-off", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
design/hvn_pkg.sv
design/hvn_if.sv
design/hvn_div_cell.sv
design/hvn_hash_lane.sv
design/hashed_value_noise_1d.sv
tb/sv/hashed_value_noise_1d_checker.sv
tb/sv/hashed_value_noise_1d_test.sv
